/* rtl/dcbs_pkg.sv */
// Shared types, codes and helper functions for the DAC current bisection search.
package dcbs_pkg;

    // Field widths
    localparam int DAC_BITS   = 10;
    localparam int SENSE_BITS = 16;

    // Register reset values and APB geometry
    localparam logic [DAC_BITS-1:0] DAC_LOW_RESET  = DAC_BITS'(0);
    localparam logic [DAC_BITS-1:0] DAC_HIGH_RESET = DAC_BITS'(1023);
    localparam int APB_ADDR_BITS = 3;
    localparam int APB_DATA_BITS = 32;

    // Register indexes
    localparam logic REG_DAC_LOW  = 1'b0;
    localparam logic REG_DAC_HIGH = 1'b1;

    // Input item mode codes
    localparam logic MODE_START   = 1'b0;
    localparam logic MODE_READING = 1'b1;

    // Result kind codes
    localparam logic KIND_DRIVE = 1'b0;
    localparam logic KIND_DONE  = 1'b1;

    // Result status codes
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_BRACKET = 2'd1;
    localparam logic [1:0] STATUS_RANGE   = 2'd2;

    // Search phases
    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_LOW   = 3'd1,
        PH_HIGH  = 3'd2,
        PH_MID   = 3'd3,
        PH_FINAL = 3'd4
    } phase_t;

    typedef struct packed {
        logic                         mode;
        logic signed [SENSE_BITS-1:0] target;
        logic signed [SENSE_BITS-1:0] reading;
    } in_item_t;

    typedef struct packed {
        logic                         kind;
        logic [DAC_BITS-1:0]          dac_code;
        logic [1:0]                   status;
        logic signed [SENSE_BITS-1:0] final_current;
    } out_item_t;

    // Search bounds from the register block
    typedef struct packed {
        logic [DAC_BITS-1:0] dac_low;
        logic [DAC_BITS-1:0] dac_high;
    } cfg_t;

    // v lies strictly between a and b, in either order
    function automatic logic strictly_between(
        input logic signed [SENSE_BITS-1:0] v,
        input logic signed [SENSE_BITS-1:0] a,
        input logic signed [SENSE_BITS-1:0] b
    );
        return ((v > a) && (v < b)) || ((v < a) && (v > b));
    endfunction

    // |a - b| without overflow
    function automatic logic [SENSE_BITS:0] abs_diff(
        input logic signed [SENSE_BITS-1:0] a,
        input logic signed [SENSE_BITS-1:0] b
    );
        logic signed [SENSE_BITS:0] d;
        d = (SENSE_BITS+1)'(a) - (SENSE_BITS+1)'(b);
        return d[SENSE_BITS] ? (SENSE_BITS+1)'(-d) : (SENSE_BITS+1)'(d);
    endfunction

endpackage

/* rtl/dcbs_cfg.sv */
// APB register block holding the DAC search bounds.
module dcbs_cfg (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [dcbs_pkg::APB_ADDR_BITS-1:0]     paddr,
    input  logic [dcbs_pkg::APB_DATA_BITS-1:0]     pwdata,
    output logic [dcbs_pkg::APB_DATA_BITS-1:0]     prdata,
    output logic                                   pready,
    output dcbs_pkg::cfg_t                         cfg
);

    logic [dcbs_pkg::DAC_BITS-1:0] dac_low_reg;
    logic [dcbs_pkg::DAC_BITS-1:0] dac_high_reg;
    logic                          wr_en;
    logic                          reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = paddr[2];
    assign wr_en   = psel && penable && pwrite;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dac_low_reg  <= dcbs_pkg::DAC_LOW_RESET;
            dac_high_reg <= dcbs_pkg::DAC_HIGH_RESET;
        end
        else if (wr_en)
        begin
            if (reg_sel == dcbs_pkg::REG_DAC_LOW)
            begin
                dac_low_reg <= pwdata[dcbs_pkg::DAC_BITS-1:0];
            end
            else
            begin
                dac_high_reg <= pwdata[dcbs_pkg::DAC_BITS-1:0];
            end
        end
    end

    // Read mux
    always_comb
    begin
        prdata = '0;
        case (reg_sel)
            dcbs_pkg::REG_DAC_LOW:
            begin
                prdata = dcbs_pkg::APB_DATA_BITS'(dac_low_reg);
            end
            default:
            begin
                prdata = dcbs_pkg::APB_DATA_BITS'(dac_high_reg);
            end
        endcase
    end

    assign cfg.dac_low  = dac_low_reg;
    assign cfg.dac_high = dac_high_reg;

endmodule

/* rtl/dcbs_core.sv */
// Search engine: input register, bracket state, step logic and result register.
module dcbs_core (
    input  logic                clk,
    input  logic                rst_n,
    input  dcbs_pkg::cfg_t      cfg,
    input  logic                item_valid,
    output logic                item_ready,
    input  dcbs_pkg::in_item_t  item,
    output logic                result_valid,
    input  logic                result_ready,
    output dcbs_pkg::out_item_t result
);

    localparam int DW  = dcbs_pkg::DAC_BITS;
    localparam int SW  = dcbs_pkg::SENSE_BITS;
    localparam int DW1 = DW + 1;

    // Input stage
    logic               in_valid_reg;
    dcbs_pkg::in_item_t in_data_reg;

    // Search state
    dcbs_pkg::phase_t       phase_reg, phase_next;
    logic signed [SW-1:0]   wanted_reg, wanted_next;
    logic [DW-1:0]          low_code_reg, low_code_next;
    logic [DW-1:0]          high_code_reg, high_code_next;
    logic [DW-1:0]          mid_code_reg, mid_code_next;
    logic signed [SW-1:0]   low_cur_reg, low_cur_next;
    logic signed [SW-1:0]   high_cur_reg, high_cur_next;

    // Result stage
    logic                   res_valid_reg;
    dcbs_pkg::out_item_t    res_data_reg;
    logic                   has_res;
    dcbs_pkg::out_item_t    res;

    logic                   fire;
    logic signed [SW-1:0]   rd;

    // Bracket after this reading, and probe terms
    logic [DW-1:0]          b_lo_code, b_hi_code;
    logic signed [SW-1:0]   b_lo_cur, b_hi_cur;
    logic                   in_lower, in_upper;
    logic [DW:0]            code_sum;
    logic                   span_ok;
    logic [DW-1:0]          probe_mid;
    logic [SW:0]            dist_lo, dist_hi;
    logic [DW-1:0]          near_code;

    assign fire       = in_valid_reg && (!res_valid_reg || result_ready);
    assign item_ready = !in_valid_reg || fire;
    assign rd         = in_data_reg.reading;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (item_ready)
        begin
            in_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            in_data_reg <= item;
        end
    end

    // Midpoint reading picks the half that still holds the target
    assign in_lower = dcbs_pkg::strictly_between(wanted_reg, low_cur_reg, rd);
    assign in_upper = dcbs_pkg::strictly_between(wanted_reg, rd, high_cur_reg);

    always_comb
    begin
        b_lo_code = low_code_reg;
        b_hi_code = high_code_reg;
        b_lo_cur  = low_cur_reg;
        b_hi_cur  = high_cur_reg;
        case (phase_reg)
            dcbs_pkg::PH_HIGH:
            begin
                b_hi_cur = rd;
            end
            dcbs_pkg::PH_MID:
            begin
                if (in_lower)
                begin
                    b_hi_code = mid_code_reg;
                    b_hi_cur  = rd;
                end
                else if (in_upper)
                begin
                    b_lo_code = mid_code_reg;
                    b_lo_cur  = rd;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Next probe: midpoint while the bracket is wider than one step, else nearer end
    assign code_sum  = DW1'(b_lo_code) + DW1'(b_hi_code);
    assign span_ok   = DW1'(b_hi_code) > (DW1'(b_lo_code) + DW1'(1));
    assign probe_mid = code_sum[DW:1];
    assign dist_lo   = dcbs_pkg::abs_diff(wanted_reg, b_lo_cur);
    assign dist_hi   = dcbs_pkg::abs_diff(wanted_reg, b_hi_cur);
    assign near_code = (dist_hi < dist_lo) ? b_hi_code : b_lo_code;

    // Step logic
    always_comb
    begin
        phase_next     = phase_reg;
        wanted_next    = wanted_reg;
        low_code_next  = low_code_reg;
        high_code_next = high_code_reg;
        mid_code_next  = mid_code_reg;
        low_cur_next   = low_cur_reg;
        high_cur_next  = high_cur_reg;
        has_res        = 1'b0;
        res            = '0;

        if (in_data_reg.mode == dcbs_pkg::MODE_START)
        begin
            wanted_next    = in_data_reg.target;
            low_code_next  = cfg.dac_low;
            high_code_next = cfg.dac_high;
            mid_code_next  = '0;
            phase_next     = dcbs_pkg::PH_LOW;
            has_res        = 1'b1;
            res.kind       = dcbs_pkg::KIND_DRIVE;
            res.dac_code   = cfg.dac_low;
        end
        else
        begin
            case (phase_reg)
                dcbs_pkg::PH_LOW:
                begin
                    low_cur_next = rd;
                    phase_next   = dcbs_pkg::PH_HIGH;
                    has_res      = 1'b1;
                    res.kind     = dcbs_pkg::KIND_DRIVE;
                    res.dac_code = high_code_reg;
                end
                dcbs_pkg::PH_HIGH, dcbs_pkg::PH_MID:
                begin
                    has_res = 1'b1;
                    if (phase_reg == dcbs_pkg::PH_HIGH &&
                        !dcbs_pkg::strictly_between(wanted_reg, low_cur_reg, rd))
                    begin
                        high_cur_next = rd;
                        phase_next    = dcbs_pkg::PH_IDLE;
                        res.kind      = dcbs_pkg::KIND_DONE;
                        res.status    = dcbs_pkg::STATUS_BRACKET;
                    end
                    else if (phase_reg == dcbs_pkg::PH_MID && !in_lower && !in_upper)
                    begin
                        // exact hit ends the search, anything else is out of range
                        phase_next = dcbs_pkg::PH_IDLE;
                        res.kind   = dcbs_pkg::KIND_DONE;
                        if (rd == wanted_reg)
                        begin
                            res.status        = dcbs_pkg::STATUS_OK;
                            res.final_current = rd;
                        end
                        else
                        begin
                            res.status = dcbs_pkg::STATUS_RANGE;
                        end
                    end
                    else
                    begin
                        low_code_next  = b_lo_code;
                        high_code_next = b_hi_code;
                        low_cur_next   = b_lo_cur;
                        high_cur_next  = b_hi_cur;
                        res.kind       = dcbs_pkg::KIND_DRIVE;
                        if (span_ok)
                        begin
                            mid_code_next = probe_mid;
                            phase_next    = dcbs_pkg::PH_MID;
                            res.dac_code  = probe_mid;
                        end
                        else
                        begin
                            phase_next   = dcbs_pkg::PH_FINAL;
                            res.dac_code = near_code;
                        end
                    end
                end
                dcbs_pkg::PH_FINAL:
                begin
                    phase_next        = dcbs_pkg::PH_IDLE;
                    has_res           = 1'b1;
                    res.kind          = dcbs_pkg::KIND_DONE;
                    res.status        = dcbs_pkg::STATUS_OK;
                    res.final_current = rd;
                end
                default:
                begin
                    // reading while idle is dropped
                end
            endcase
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= dcbs_pkg::PH_IDLE;
            wanted_reg    <= '0;
            low_code_reg  <= '0;
            high_code_reg <= '0;
            mid_code_reg  <= '0;
            low_cur_reg   <= '0;
            high_cur_reg  <= '0;
        end
        else if (fire)
        begin
            phase_reg     <= phase_next;
            wanted_reg    <= wanted_next;
            low_code_reg  <= low_code_next;
            high_code_reg <= high_code_next;
            mid_code_reg  <= mid_code_next;
            low_cur_reg   <= low_cur_next;
            high_cur_reg  <= high_cur_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (fire && has_res)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && has_res)
        begin
            res_data_reg <= res;
        end
    end

    assign result_valid = res_valid_reg;
    assign result       = res_data_reg;

endmodule

/* rtl/dac_current_bisection_search.sv */
// Top level of the DAC current bisection search.
//
// Use: program dac_low (0x0) and dac_high (0x4) over APB while the block is
// idle. Send a start item (mode 0) with the target current; the block answers
// with a drive item giving the DAC code to set. After setting the code and
// converting, send a reading item (mode 1); each reading yields the next drive
// item or a finished item with status and final current. A reading with no
// search running is dropped. A start item during a search restarts it.
// An item is taken into an input register, the step logic works on it
// combinationally and its result is registered in the result register.
// Throughput: one item per cycle while the receiver takes results, set by the
// single registered step stage; the input and result registers run concurrently.
// Reset clears the search to idle, empties both stages and restores the
// bounds to 0 and 1023. When the receiver stalls, the result is held and the
// input register still takes one more item; after that item_ready drops
// until the result is taken.
module dac_current_bisection_search (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [dcbs_pkg::APB_ADDR_BITS-1:0] paddr,
    input  logic [dcbs_pkg::APB_DATA_BITS-1:0] pwdata,
    output logic [dcbs_pkg::APB_DATA_BITS-1:0] prdata,
    output logic                               pready,
    input  logic                               item_valid,
    output logic                               item_ready,
    input  dcbs_pkg::in_item_t                 item,
    output logic                               result_valid,
    input  logic                               result_ready,
    output dcbs_pkg::out_item_t                result
);

    dcbs_pkg::cfg_t cfg;

    // Bound registers
    dcbs_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Search engine
    dcbs_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the DAC current bisection search: directed rows, then random.
module testbench;

    localparam int DW            = dcbs_pkg::DAC_BITS;
    localparam int SW            = dcbs_pkg::SENSE_BITS;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 400;
    localparam int NUM_PHASES    = 8;
    localparam int PHASE_ITEMS   = 250;
    localparam int PLAN_ROWS     = 31;

    // Directed row kinds: register write, or an item checked one of four ways
    typedef enum {ROW_CFG, ROW_SILENT, ROW_PRED, ROW_DRIVE, ROW_DONE} row_kind_t;

    typedef struct {
        row_kind_t kind;
        logic      sel;     // mode for items, register index for writes
        int        val;     // target or reading for items, value for writes
        int        exp_a;   // expected code, or status
        int        exp_b;   // expected final current
    } plan_row_t;

    logic clk;
    logic rst_n = 1'b0;

    logic                               psel    = 1'b0;
    logic                               penable = 1'b0;
    logic                               pwrite  = 1'b0;
    logic [dcbs_pkg::APB_ADDR_BITS-1:0] paddr   = '0;
    logic [dcbs_pkg::APB_DATA_BITS-1:0] pwdata  = '0;
    logic [dcbs_pkg::APB_DATA_BITS-1:0] prdata;
    logic                               pready;
    logic                               item_valid   = 1'b0;
    logic                               item_ready;
    dcbs_pkg::in_item_t                 item         = '0;
    logic                               result_valid;
    logic                               result_ready = 1'b0;
    dcbs_pkg::out_item_t                result;

    dac_current_bisection_search u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    // Search tracker state and bounds as the block should hold them
    dcbs_pkg::phase_t     srch_phase = dcbs_pkg::PH_IDLE;
    logic signed [SW-1:0] want_cur   = '0;
    logic signed [SW-1:0] lo_cur     = '0;
    logic signed [SW-1:0] hi_cur     = '0;
    logic [DW-1:0]        lo_code    = '0;
    logic [DW-1:0]        hi_code    = '0;
    logic [DW-1:0]        mid_code_q = '0;
    logic [DW-1:0]        bound_lo   = dcbs_pkg::DAC_LOW_RESET;
    logic [DW-1:0]        bound_hi   = dcbs_pkg::DAC_HIGH_RESET;

    dcbs_pkg::out_item_t pending_results [$];
    int                  mismatch_count = 0;
    int                  stim_count     = 0;
    bit                  steady         = 1'b0;
    bit                  hold_req       = 1'b0;

    // Simulated DAC plus sensor: monotonic line, clipped to the sense range
    int            plant_off;
    int            plant_slope;
    logic [DW-1:0] driven_code = '0;

    function automatic logic signed [SW-1:0] plant_current(logic [DW-1:0] code);
        int v;
        v = plant_off + plant_slope * int'(code);
        if (v > 32767)
            v = 32767;
        else if (v < -32768)
            v = -32768;
        return SW'(v);
    endfunction

    function automatic bit lies_between(int v, int a, int b);
        return (v > a && v < b) || (v < a && v > b);
    endfunction

    function automatic dcbs_pkg::out_item_t drive_of(logic [DW-1:0] code);
        dcbs_pkg::out_item_t r;
        r = '0;
        r.kind = dcbs_pkg::KIND_DRIVE;
        r.dac_code = code;
        return r;
    endfunction

    function automatic dcbs_pkg::out_item_t finish_with(logic [1:0] st,
                                                        logic signed [SW-1:0] cur);
        dcbs_pkg::out_item_t r;
        r = '0;
        srch_phase = dcbs_pkg::PH_IDLE;
        r.kind = dcbs_pkg::KIND_DONE;
        r.status = st;
        r.final_current = (st == dcbs_pkg::STATUS_OK) ? cur : '0;
        return r;
    endfunction

    // Midpoint of the bracket, or the nearer end once the codes touch
    function automatic dcbs_pkg::out_item_t probe_from_bracket();
        logic [DW:0] sum;
        int dh;
        int dl;
        if (int'(hi_code) > int'(lo_code) + 1)
        begin
            sum = {1'b0, hi_code} + {1'b0, lo_code};
            mid_code_q = sum[DW:1];
            srch_phase = dcbs_pkg::PH_MID;
            return drive_of(mid_code_q);
        end
        dh = int'(want_cur) - int'(hi_cur);
        dl = int'(want_cur) - int'(lo_cur);
        if (dh < 0)
            dh = -dh;
        if (dl < 0)
            dl = -dl;
        srch_phase = dcbs_pkg::PH_FINAL;
        return drive_of(dh < dl ? hi_code : lo_code);
    endfunction

    // Advance the search by one accepted item; emits says a result follows
    function automatic void next_search_result(input dcbs_pkg::in_item_t it,
                                               output bit emits,
                                               output dcbs_pkg::out_item_t res);
        logic signed [SW-1:0] r;
        r = it.reading;
        emits = 1'b1;
        res = '0;
        if (it.mode == dcbs_pkg::MODE_START)
        begin
            want_cur   = it.target;
            lo_code    = bound_lo;
            hi_code    = bound_hi;
            mid_code_q = '0;
            srch_phase = dcbs_pkg::PH_LOW;
            res = drive_of(lo_code);
        end
        else
        begin
            case (srch_phase)
                dcbs_pkg::PH_LOW:
                begin
                    lo_cur = r;
                    srch_phase = dcbs_pkg::PH_HIGH;
                    res = drive_of(hi_code);
                end
                dcbs_pkg::PH_HIGH:
                begin
                    hi_cur = r;
                    if (!lies_between(want_cur, lo_cur, hi_cur))
                        res = finish_with(dcbs_pkg::STATUS_BRACKET, '0);
                    else
                        res = probe_from_bracket();
                end
                dcbs_pkg::PH_MID:
                begin
                    if (lies_between(want_cur, lo_cur, r))
                    begin
                        hi_code = mid_code_q;
                        hi_cur  = r;
                        res = probe_from_bracket();
                    end
                    else if (lies_between(want_cur, r, hi_cur))
                    begin
                        lo_code = mid_code_q;
                        lo_cur  = r;
                        res = probe_from_bracket();
                    end
                    else if (r == want_cur)
                        res = finish_with(dcbs_pkg::STATUS_OK, r);
                    else
                        res = finish_with(dcbs_pkg::STATUS_RANGE, '0);
                end
                dcbs_pkg::PH_FINAL:
                    res = finish_with(dcbs_pkg::STATUS_OK, r);
                default:
                    emits = 1'b0;
            endcase
        end
    endfunction

    // Offer one item, record its expectation at acceptance, maybe idle after
    task automatic send_item(input dcbs_pkg::in_item_t it, input row_kind_t how,
                             input dcbs_pkg::out_item_t fixed);
        bit                  emits;
        dcbs_pkg::out_item_t res;
        item       <= it;
        item_valid <= 1'b1;
        do @(posedge clk); while (item_ready !== 1'b1);
        next_search_result(it, emits, res);
        if (emits)
        begin
            stim_count++;
            if (res.kind == dcbs_pkg::KIND_DRIVE)
                driven_code = res.dac_code;
        end
        case (how)
            ROW_PRED:   if (emits) pending_results.push_back(res);
            ROW_SILENT: ;
            default:    pending_results.push_back(fixed);
        endcase
        // idle cycles, each taken with the same odds
        while (!steady && $urandom_range(0, 99) < 29)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic send_plant_reading(bit noisy);
        dcbs_pkg::in_item_t it;
        it = '0;
        it.mode    = dcbs_pkg::MODE_READING;
        it.target  = SW'($urandom);
        it.reading = noisy ? SW'($urandom) : plant_current(driven_code);
        send_item(it, ROW_PRED, '0);
    endtask

    // One search on a fresh plant; may be cut short so the next start restarts it
    task automatic run_search();
        dcbs_pkg::in_item_t it;
        int                 pick;
        int                 c;
        if (srch_phase == dcbs_pkg::PH_IDLE && $urandom_range(0, 99) < 5)
            send_plant_reading(1'b1);
        plant_slope = $urandom_range(0, 128) - 64;
        plant_off   = $urandom_range(0, 40000) - 20000;
        c    = $urandom_range(int'(bound_lo), int'(bound_hi));
        pick = $urandom_range(0, 99);
        it = '0;
        it.mode    = dcbs_pkg::MODE_START;
        it.reading = SW'($urandom);
        if (pick < 55)
            it.target = plant_current(c) + SW'($urandom_range(0, 4) - 2);
        else if (pick < 75)
            it.target = plant_current(c);
        else if (pick < 90)
            it.target = SW'($urandom);
        else
            it.target = plant_current(bound_lo);
        send_item(it, ROW_PRED, '0);
        while (srch_phase != dcbs_pkg::PH_IDLE)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 2)
                return;
            send_plant_reading(pick < 5);
        end
    endtask

    // Stop offering, let every result arrive, then let the block sit quiet
    task automatic settle_block();
        item_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [DW-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= dcbs_pkg::APB_DATA_BITS'(val);
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == dcbs_pkg::REG_DAC_LOW)
            bound_lo = val;
        else
            bound_hi = val;
    endtask

    // Receiver: random back-pressure, one long hold-off on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                result_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            result_ready <= steady || ($urandom_range(0, 99) >= 29);
        end
    end

    task automatic note_mismatch(string field, logic signed [31:0] want,
                                 logic signed [31:0] got);
        mismatch_count++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    endtask

    // Result checker
    always @(posedge clk)
    begin
        dcbs_pkg::out_item_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: unexpected result, expected none, actual %h", $time, result);
            end
            else
            begin
                want = pending_results.pop_front();
                if (result.kind !== want.kind)
                    note_mismatch("kind", want.kind, result.kind);
                if (result.dac_code !== want.dac_code)
                    note_mismatch("dac_code", want.dac_code, result.dac_code);
                if (result.status !== want.status)
                    note_mismatch("status", want.status, result.status);
                if (result.final_current !== want.final_current)
                    note_mismatch("final_current", want.final_current, result.final_current);
            end
        end
    end

    plan_row_t plan [PLAN_ROWS] = '{
        // reset bounds: idle reading, equal-target stop, target at an end, restart
        '{ROW_SILENT, dcbs_pkg::MODE_READING, 32767, 0, 0},
        '{ROW_DRIVE, dcbs_pkg::MODE_START, 0, 0, 0},
        '{ROW_DRIVE, dcbs_pkg::MODE_READING, -32768, 1023, 0},
        '{ROW_DRIVE, dcbs_pkg::MODE_READING, 32767, 511, 0},
        '{ROW_DONE, dcbs_pkg::MODE_READING, 0, dcbs_pkg::STATUS_OK, 0},
        '{ROW_DRIVE, dcbs_pkg::MODE_START, -32768, 0, 0},
        '{ROW_DRIVE, dcbs_pkg::MODE_READING, -32768, 1023, 0},
        '{ROW_DONE, dcbs_pkg::MODE_READING, 32767, dcbs_pkg::STATUS_BRACKET, 0},
        '{ROW_DRIVE, dcbs_pkg::MODE_START, 10, 0, 0},
        '{ROW_DRIVE, dcbs_pkg::MODE_READING, 1000, 1023, 0},
        '{ROW_DRIVE, dcbs_pkg::MODE_START, 20, 0, 0},
        '{ROW_DRIVE, dcbs_pkg::MODE_READING, 20, 1023, 0},
        '{ROW_DONE, dcbs_pkg::MODE_READING, 20, dcbs_pkg::STATUS_BRACKET, 0},
        // inverted bounds, tie at the end goes to the low-end code
        '{ROW_CFG, dcbs_pkg::REG_DAC_LOW, 1023, 0, 0},
        '{ROW_CFG, dcbs_pkg::REG_DAC_HIGH, 0, 0, 0},
        '{ROW_DRIVE, dcbs_pkg::MODE_START, 5, 1023, 0},
        '{ROW_DRIVE, dcbs_pkg::MODE_READING, 0, 0, 0},
        '{ROW_DRIVE, dcbs_pkg::MODE_READING, 10, 1023, 0},
        '{ROW_DONE, dcbs_pkg::MODE_READING, 7, dcbs_pkg::STATUS_OK, 7},
        // equal bounds
        '{ROW_CFG, dcbs_pkg::REG_DAC_LOW, 1000, 0, 0},
        '{ROW_CFG, dcbs_pkg::REG_DAC_HIGH, 1000, 0, 0},
        '{ROW_DRIVE, dcbs_pkg::MODE_START, 0, 1000, 0},
        '{ROW_DRIVE, dcbs_pkg::MODE_READING, 3, 1000, 0},
        '{ROW_DONE, dcbs_pkg::MODE_READING, 3, dcbs_pkg::STATUS_BRACKET, 0},
        // one bisection step, then the nearer end
        '{ROW_CFG, dcbs_pkg::REG_DAC_LOW, 0, 0, 0},
        '{ROW_CFG, dcbs_pkg::REG_DAC_HIGH, 2, 0, 0},
        '{ROW_DRIVE, dcbs_pkg::MODE_START, 50, 0, 0},
        '{ROW_DRIVE, dcbs_pkg::MODE_READING, 0, 2, 0},
        '{ROW_PRED, dcbs_pkg::MODE_READING, 100, 0, 0},
        '{ROW_PRED, dcbs_pkg::MODE_READING, 60, 0, 0},
        '{ROW_DONE, dcbs_pkg::MODE_READING, 61, dcbs_pkg::STATUS_OK, 61}
    };

    // Main sequence
    initial
    begin
        dcbs_pkg::in_item_t  it;
        dcbs_pkg::out_item_t fixed;
        logic [DW-1:0]       lo;
        logic [DW-1:0]       hi;
        int                  quota;
        bit                  held;
        bit                  paused;
        held   = 1'b0;
        paused = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_CFG)
            begin
                settle_block();
                write_reg(plan[i].sel, DW'(plan[i].val));
            end
            else
            begin
                it = '0;
                it.mode = plan[i].sel;
                if (plan[i].sel == dcbs_pkg::MODE_START)
                    it.target = SW'(plan[i].val);
                else
                    it.reading = SW'(plan[i].val);
                fixed = '0;
                if (plan[i].kind == ROW_DRIVE)
                    fixed = drive_of(DW'(plan[i].exp_a));
                else if (plan[i].kind == ROW_DONE)
                begin
                    fixed.kind          = dcbs_pkg::KIND_DONE;
                    fixed.status        = 2'(plan[i].exp_a);
                    fixed.final_current = SW'(plan[i].exp_b);
                end
                send_item(it, plan[i].kind, fixed);
            end
        end

        // random searches over several bound settings
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            settle_block();
            case (p)
                0:
                begin
                    lo = '0;
                    hi = DW'(1023);
                end
                1:
                begin
                    lo = DW'(1023);
                    hi = '0;
                end
                2:
                begin
                    lo = '0;
                    hi = '0;
                end
                3:
                begin
                    lo = DW'(1023);
                    hi = DW'(1023);
                end
                4:
                begin
                    lo = '0;
                    hi = DW'(1);
                end
                5:
                begin
                    lo = DW'($urandom_range(0, 1008));
                    hi = lo + DW'($urandom_range(0, 15));
                end
                6:
                begin
                    lo = DW'($urandom);
                    hi = DW'($urandom);
                end
                default:
                begin
                    lo = '0;
                    hi = DW'(1023);
                end
            endcase
            write_reg(dcbs_pkg::REG_DAC_LOW, lo);
            write_reg(dcbs_pkg::REG_DAC_HIGH, hi);
            steady = (p == NUM_PHASES - 1);
            quota = stim_count + PHASE_ITEMS;
            while (stim_count < quota)
            begin
                if (p == 0 && !held && stim_count > quota - PHASE_ITEMS + 40)
                begin
                    hold_req = 1'b1;
                    held = 1'b1;
                end
                if (p == 6 && !paused && stim_count > quota - PHASE_ITEMS / 2)
                begin
                    item_valid <= 1'b0;
                    while (pending_results.size() != 0) @(posedge clk);
                    paused = 1'b1;
                end
                run_search();
            end
            // close any open search before the bounds change
            while (srch_phase != dcbs_pkg::PH_IDLE)
                send_plant_reading(1'b0);
        end

        settle_block();
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
